// ----- design/amsd_pkg.sv -----
// ----------------------------------------------------------------------------
// amsd_pkg - shared types and constants of the motion settle detector
// Register indexes, reset values, phase codes, counter limits and the
// control structs that pass between the pipeline, the lanes and the merge.
// ----------------------------------------------------------------------------
`default_nettype none

package amsd_pkg;

  // Default geometry
  localparam int unsigned WINDOW_DEF      = 16;
  localparam int unsigned SAMPLE_BITS_DEF = 12;

  // Configuration port
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = 12;

  localparam logic [CFG_IDX_BITS-1:0] CFG_WARMUP       = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_STEADY_LIMIT = 2'd2;

  // Register widths and reset values
  localparam int unsigned WARM_BITS = 10;
  localparam int unsigned THR_BITS  = 12;
  localparam int unsigned LIM_BITS  = 8;

  localparam logic [WARM_BITS-1:0] WARMUP_RST = 10'd100;
  localparam logic [THR_BITS-1:0]  THR_RST    = 12'd30;
  localparam logic [LIM_BITS-1:0]  LIM_RST    = 8'd20;

  // Counters
  localparam int unsigned CNT_BITS = 11;
  localparam int unsigned CTR_BITS = 8;

  localparam logic [CNT_BITS-1:0] CNT_MAX = 11'd2047;
  localparam logic [CTR_BITS-1:0] CTR_MAX = 8'd255;

  // Reported phase
  typedef logic [1:0] phase_t;

  localparam phase_t PH_WARMUP = 2'd0;
  localparam phase_t PH_FILL   = 2'd1;
  localparam phase_t PH_TRACK  = 2'd2;
  localparam phase_t PH_DONE   = 2'd3;

  // Lane update request from the merge stage
  typedef struct packed {
    logic push;   // store the sample and add it to the sum
    logic drop;   // subtract the oldest entry first
    logic clear;  // restart: zero the sum and the ring index
  } lane_ctl_t;

  // Load enables of the two divider stages
  typedef struct packed {
    logic en1;
    logic en2;
  } split_ctl_t;

endpackage

`default_nettype wire

// ----- design/accel_motion_settle_detector.sv -----
// ----------------------------------------------------------------------------
// accel_motion_settle_detector - moving average motion and settle detector
// Three axis lanes keep a WINDOW-deep ring and running sum each; a merge
// stage turns their deviation flags into motion, steady and roll counts.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (in_valid / in_stall) carry either a sample (in_cmd = 0) or a
//   restart (in_cmd = 1). Every input beat yields exactly one result beat on
//   out_valid / out_stall, in order.
//   Configuration writes on cfg_valid / cfg_ready (always ready) set the
//   warm-up length, the motion threshold and the steady limit; write them
//   only while no beat is in flight.
//   An accepted input beat passes two divider stages that split each sample
//   by WINDOW; then the state update loads the result register.
//   Throughput: one beat per cycle unless out_stall holds it; the state update
//   sets the rate: ring read, mixed-radix sum update, threshold compare per lane.
//   Stall: a stalled result holds; the pipeline fills behind it and in_stall
//   rises once all three stages hold a beat.
//   Reset: clears counters, sums, the done flag and the registers to their
//   defaults (warm-up 100, threshold 30, limit 20). The rings are not
//   cleared; there is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module accel_motion_settle_detector #(
  parameter int unsigned WINDOW      = amsd_pkg::WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS = amsd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_cmd,
  input  logic [SAMPLE_BITS-1:0]             in_accel_x,
  input  logic [SAMPLE_BITS-1:0]             in_accel_y,
  input  logic [SAMPLE_BITS-1:0]             in_accel_z,
  // Result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output amsd_pkg::phase_t                   out_phase,
  output logic                               out_moving,
  output logic [SAMPLE_BITS-1:0]             out_avg_x,
  output logic [SAMPLE_BITS-1:0]             out_avg_y,
  output logic [SAMPLE_BITS-1:0]             out_avg_z,
  output logic [amsd_pkg::CTR_BITS-1:0]      out_steady_count,
  output logic [amsd_pkg::CTR_BITS-1:0]      out_roll_count,
  output logic                               out_settled,
  // Configuration port
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [amsd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [amsd_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  localparam int unsigned RB = $clog2(WINDOW);

  logic                          v1_r;
  logic                          v2_r;
  logic                          v3_r;
  logic                          cmd1_r;
  logic                          cmd2_r;
  logic                          adv1;
  logic                          adv2;
  logic                          adv3;
  amsd_pkg::split_ctl_t          split_ctl;
  amsd_pkg::lane_ctl_t           lane_ctl;

  logic [amsd_pkg::WARM_BITS-1:0] warm_r;
  logic [amsd_pkg::THR_BITS-1:0]  thr_r;
  logic [amsd_pkg::LIM_BITS-1:0]  lim_r;

  logic [SAMPLE_BITS-1:0] s_x, s_y, s_z;
  logic [SAMPLE_BITS-1:0] q_x, q_y, q_z;
  logic [RB-1:0]          r_x, r_y, r_z;
  logic [2:0]             lane_over;

  // Pipeline advance: a stage moves when the one after it can take a beat
  assign adv3 = !v3_r || !out_stall;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;

  assign in_stall      = !adv1;
  assign split_ctl.en1 = in_valid && adv1;
  assign split_ctl.en2 = v1_r && adv2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
    end
  end

  // Carry the command bit alongside the divider stages
  always_ff @(posedge clk) begin
    if (split_ctl.en1) cmd1_r <= in_cmd;
    if (split_ctl.en2) cmd2_r <= cmd1_r;
  end

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warm_r <= amsd_pkg::WARMUP_RST;
      thr_r  <= amsd_pkg::THR_RST;
      lim_r  <= amsd_pkg::LIM_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        amsd_pkg::CFG_WARMUP:       warm_r <= cfg_data[amsd_pkg::WARM_BITS-1:0];
        amsd_pkg::CFG_THRESHOLD:    thr_r  <= cfg_data[amsd_pkg::THR_BITS-1:0];
        amsd_pkg::CFG_STEADY_LIMIT: lim_r  <= cfg_data[amsd_pkg::LIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Divider stages, one per axis
  amsd_split #(.WINDOW(WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_split_x (
    .clk(clk), .ctl(split_ctl), .sample(in_accel_x), .s_q(s_x), .q_q(q_x), .r_q(r_x)
  );
  amsd_split #(.WINDOW(WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_split_y (
    .clk(clk), .ctl(split_ctl), .sample(in_accel_y), .s_q(s_y), .q_q(q_y), .r_q(r_y)
  );
  amsd_split #(.WINDOW(WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_split_z (
    .clk(clk), .ctl(split_ctl), .sample(in_accel_z), .s_q(s_z), .q_q(q_z), .r_q(r_z)
  );

  // Axis lanes
  amsd_lane #(.WINDOW(WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_lane_x (
    .clk(clk), .rst_n(rst_n), .ctl(lane_ctl), .sample(s_x), .s_quo(q_x),
    .s_rem(r_x), .thr(thr_r), .avg(out_avg_x), .over(lane_over[0])
  );
  amsd_lane #(.WINDOW(WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_lane_y (
    .clk(clk), .rst_n(rst_n), .ctl(lane_ctl), .sample(s_y), .s_quo(q_y),
    .s_rem(r_y), .thr(thr_r), .avg(out_avg_y), .over(lane_over[1])
  );
  amsd_lane #(.WINDOW(WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_lane_z (
    .clk(clk), .rst_n(rst_n), .ctl(lane_ctl), .sample(s_z), .s_quo(q_z),
    .s_rem(r_z), .thr(thr_r), .avg(out_avg_z), .over(lane_over[2])
  );

  // Merge the lane flags and update the counters
  amsd_merge #(.WINDOW(WINDOW)) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (v2_r && adv3),
    .cmd       (cmd2_r),
    .warm      (warm_r),
    .lim       (lim_r),
    .lane_over (lane_over),
    .lane_ctl  (lane_ctl),
    .phase     (out_phase),
    .moving    (out_moving),
    .steady    (out_steady_count),
    .roll      (out_roll_count),
    .settled   (out_settled)
  );

  assign out_valid = v3_r;

endmodule

`default_nettype wire

// ----- design/amsd_split.sv -----
// ----------------------------------------------------------------------------
// amsd_split - split one axis sample into quotient and remainder by WINDOW
// Stage one multiplies by a fixed reciprocal, stage two recovers the
// remainder, so the lane can keep its running sum in mixed radix.
// ----------------------------------------------------------------------------
`default_nettype none

module amsd_split #(
  parameter int unsigned WINDOW      = amsd_pkg::WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS = amsd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                      clk,
  input  amsd_pkg::split_ctl_t      ctl,
  input  logic [SAMPLE_BITS-1:0]    sample,
  output logic [SAMPLE_BITS-1:0]    s_q,
  output logic [SAMPLE_BITS-1:0]    q_q,
  output logic [$clog2(WINDOW)-1:0] r_q
);

  localparam int unsigned RB = $clog2(WINDOW);
  localparam int unsigned KB = SAMPLE_BITS + RB;
  localparam int unsigned PB = SAMPLE_BITS + KB;
  localparam int unsigned QW = SAMPLE_BITS + RB;
  // ceil(2^KB / WINDOW): exact floor division for every SAMPLE_BITS input
  localparam logic [KB-1:0] Recip =
    KB'(((64'd1 << KB) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

  logic [SAMPLE_BITS-1:0] s1_r;
  logic [PB-1:0]          prod_r;
  logic [PB-1:0]          prod_nxt;
  logic [SAMPLE_BITS-1:0] quo;
  logic [QW-1:0]          quo_w;
  logic [QW-1:0]          rem_w;
  logic [SAMPLE_BITS-1:0] s2_r;
  logic [SAMPLE_BITS-1:0] q2_r;
  logic [RB-1:0]          r2_r;

  // Multiply by the reciprocal
  assign prod_nxt = {{KB{1'b0}}, sample} * {{SAMPLE_BITS{1'b0}}, Recip};

  always_ff @(posedge clk) begin
    if (ctl.en1) begin
      s1_r   <= sample;
      prod_r <= prod_nxt;
    end
  end

  // Take the quotient and subtract it back out for the remainder
  assign quo   = prod_r[KB +: SAMPLE_BITS];
  assign quo_w = {{RB{1'b0}}, quo} * QW'(WINDOW);
  assign rem_w = {{RB{1'b0}}, s1_r} - quo_w;

  always_ff @(posedge clk) begin
    if (ctl.en2) begin
      s2_r <= s1_r;
      q2_r <= quo;
      r2_r <= rem_w[RB-1:0];
    end
  end

  assign s_q = s2_r;
  assign q_q = q2_r;
  assign r_q = r2_r;

endmodule

`default_nettype wire

// ----- design/amsd_lane.sv -----
// ----------------------------------------------------------------------------
// amsd_lane - one axis: sample ring, running sum and deviation test
// The sum is held as quotient and remainder by WINDOW; the quotient is the
// moving average. The deviation flag compares the sample with the new average.
// ----------------------------------------------------------------------------
`default_nettype none

module amsd_lane #(
  parameter int unsigned WINDOW      = amsd_pkg::WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS = amsd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  amsd_pkg::lane_ctl_t           ctl,
  input  logic [SAMPLE_BITS-1:0]        sample,
  input  logic [SAMPLE_BITS-1:0]        s_quo,
  input  logic [$clog2(WINDOW)-1:0]     s_rem,
  input  logic [amsd_pkg::THR_BITS-1:0] thr,
  output logic [SAMPLE_BITS-1:0]        avg,
  output logic                          over
);

  localparam int unsigned RB = $clog2(WINDOW);
  localparam int unsigned TW = RB + 2;
  localparam int unsigned CW = (SAMPLE_BITS > amsd_pkg::THR_BITS) ?
                               SAMPLE_BITS : amsd_pkg::THR_BITS;
  localparam logic signed [TW-1:0] WinS = TW'(WINDOW);
  localparam logic [RB-1:0]        LastIdx = RB'(WINDOW - 1);

  logic [SAMPLE_BITS-1:0] ring_q [WINDOW];
  logic [RB-1:0]          ring_r [WINDOW];

  logic [RB-1:0]          idx_r;
  logic [RB-1:0]          idx_nxt;
  logic [SAMPLE_BITS-1:0] sum_q_r;
  logic [SAMPLE_BITS-1:0] sum_q_nxt;
  logic [RB-1:0]          sum_rem_r;
  logic [RB-1:0]          sum_rem_nxt;

  logic [SAMPLE_BITS-1:0] old_q;
  logic [RB-1:0]          old_r;
  logic signed [TW-1:0]   tr;
  logic signed [TW-1:0]   tr_adj;
  logic                   inc;
  logic                   dec;
  logic [SAMPLE_BITS-1:0] dev;

  // Add the new sample, drop the oldest, carry between remainder and quotient
  always_comb begin
    old_q  = ctl.drop ? ring_q[idx_r] : '0;
    old_r  = ctl.drop ? ring_r[idx_r] : '0;
    tr     = $signed({2'b00, sum_rem_r}) + $signed({2'b00, s_rem})
           - $signed({2'b00, old_r});
    tr_adj = tr;
    inc    = 1'b0;
    dec    = 1'b0;
    if (tr >= WinS) begin
      tr_adj = tr - WinS;
      inc    = 1'b1;
    end else if (tr[TW-1]) begin
      tr_adj = tr + WinS;
      dec    = 1'b1;
    end
    sum_rem_nxt = tr_adj[RB-1:0];
    sum_q_nxt   = sum_q_r + s_quo - old_q
                + SAMPLE_BITS'(inc) - SAMPLE_BITS'(dec);
    idx_nxt     = (idx_r == LastIdx) ? '0 : idx_r + 1'b1;
  end

  // Distance of the sample from the updated average
  always_comb begin
    dev  = (sample >= sum_q_nxt) ? sample - sum_q_nxt : sum_q_nxt - sample;
    over = CW'(dev) >= CW'(thr);
  end

  // Sum and index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      sum_q_r   <= '0;
      sum_rem_r <= '0;
    end else if (ctl.clear) begin
      idx_r     <= '0;
      sum_q_r   <= '0;
      sum_rem_r <= '0;
    end else if (ctl.push) begin
      idx_r     <= idx_nxt;
      sum_q_r   <= sum_q_nxt;
      sum_rem_r <= sum_rem_nxt;
    end
  end

  // Ring write at the oldest slot
  always_ff @(posedge clk) begin
    if (ctl.push && !ctl.clear) begin
      ring_q[idx_r] <= s_quo;
      ring_r[idx_r] <= s_rem;
    end
  end

  assign avg = sum_q_r;

endmodule

`default_nettype wire

// ----- design/amsd_merge.sv -----
// ----------------------------------------------------------------------------
// amsd_merge - phase decision, lane control and settle counters
// Combines the three lane deviation flags into one motion flag, keeps the
// sample, steady and roll counters and the sticky done flag.
// ----------------------------------------------------------------------------
`default_nettype none

module amsd_merge #(
  parameter int unsigned WINDOW = amsd_pkg::WINDOW_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           cmd,
  input  logic [amsd_pkg::WARM_BITS-1:0] warm,
  input  logic [amsd_pkg::LIM_BITS-1:0]  lim,
  input  logic [2:0]                     lane_over,
  output amsd_pkg::lane_ctl_t            lane_ctl,
  output amsd_pkg::phase_t               phase,
  output logic                           moving,
  output logic [amsd_pkg::CTR_BITS-1:0]  steady,
  output logic [amsd_pkg::CTR_BITS-1:0]  roll,
  output logic                           settled
);

  localparam int unsigned CNB = amsd_pkg::CNT_BITS;
  localparam int unsigned CTB = amsd_pkg::CTR_BITS;

  logic [CNB-1:0]   cnt_r;
  logic [CNB-1:0]   cnt_nxt;
  logic [CTB-1:0]   steady_r;
  logic [CTB-1:0]   steady_nxt;
  logic [CTB-1:0]   roll_r;
  logic [CTB-1:0]   roll_nxt;
  logic             done_r;
  logic             done_nxt;
  amsd_pkg::phase_t phase_r;
  amsd_pkg::phase_t phase_nxt;
  logic             moving_r;
  logic             moving_nxt;

  logic [CNB-1:0]   fill_end;
  logic             in_warm;
  logic             in_fill;
  logic             any_over;

  assign fill_end = {1'b0, warm} + CNB'(WINDOW);
  assign in_warm  = cnt_r < {1'b0, warm};
  assign in_fill  = !in_warm && (cnt_r < fill_end);
  assign any_over = |lane_over;

  // Decide the phase and the next counter values for this beat
  always_comb begin
    cnt_nxt    = cnt_r;
    steady_nxt = steady_r;
    roll_nxt   = roll_r;
    done_nxt   = done_r;
    phase_nxt  = amsd_pkg::PH_WARMUP;
    moving_nxt = 1'b0;
    lane_ctl   = '0;
    if (en) begin
      if (cmd) begin
        cnt_nxt        = '0;
        steady_nxt     = '0;
        roll_nxt       = '0;
        done_nxt       = 1'b0;
        lane_ctl.clear = 1'b1;
      end else begin
        if (!done_r) begin
          if (in_warm) begin
            phase_nxt = amsd_pkg::PH_WARMUP;
          end else if (in_fill) begin
            phase_nxt     = amsd_pkg::PH_FILL;
            lane_ctl.push = 1'b1;
          end else begin
            phase_nxt     = amsd_pkg::PH_TRACK;
            lane_ctl.push = 1'b1;
            lane_ctl.drop = 1'b1;
            moving_nxt    = any_over;
            // The first tracked sample only flags
            if (cnt_r > fill_end) begin
              if (any_over) begin
                if (roll_r != amsd_pkg::CTR_MAX) roll_nxt = roll_r + 1'b1;
                steady_nxt = '0;
              end else if (steady_r != amsd_pkg::CTR_MAX) begin
                steady_nxt = steady_r + 1'b1;
              end
            end
          end
          if (cnt_r != amsd_pkg::CNT_MAX) cnt_nxt = cnt_r + 1'b1;
        end
        if ((steady_nxt > lim) && (roll_nxt != '0)) done_nxt = 1'b1;
        if (done_nxt) phase_nxt = amsd_pkg::PH_DONE;
      end
    end
  end

  // Counters and sticky done flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      steady_r <= '0;
      roll_r   <= '0;
      done_r   <= 1'b0;
    end else if (en) begin
      cnt_r    <= cnt_nxt;
      steady_r <= steady_nxt;
      roll_r   <= roll_nxt;
      done_r   <= done_nxt;
    end
  end

  // Result fields that are not state
  always_ff @(posedge clk) begin
    if (en) begin
      phase_r  <= phase_nxt;
      moving_r <= moving_nxt;
    end
  end

  assign phase   = phase_r;
  assign moving  = moving_r;
  assign steady  = steady_r;
  assign roll    = roll_r;
  assign settled = done_r;

endmodule

`default_nettype wire

// ----- design/amsd_chk.sv -----
// ----------------------------------------------------------------------------
// amsd_chk - port-level checks for the motion settle detector
// Watches the result channel for held beats and consistent status fields.
// ----------------------------------------------------------------------------
`default_nettype none

module amsd_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_stall,
  input amsd_pkg::phase_t              out_phase,
  input logic                          out_moving,
  input logic [amsd_pkg::CTR_BITS-1:0] out_steady_count,
  input logic [amsd_pkg::CTR_BITS-1:0] out_roll_count,
  input logic                          out_settled
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_phase) &&
      $stable(out_settled) && $stable(out_roll_count))
    else $error("stalled result beat changed");

  // Settled results always report the done phase
  a_settled_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_settled |-> out_phase == amsd_pkg::PH_DONE)
    else $error("settled without done phase");

  // Motion is only flagged on tracked samples
  a_moving_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_moving |->
      (out_phase == amsd_pkg::PH_TRACK || out_phase == amsd_pkg::PH_DONE))
    else $error("motion flagged outside tracking");

  // Done only drops on a restart result with cleared counters
  a_settle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(out_settled) |->
      out_valid && out_phase == amsd_pkg::PH_WARMUP &&
      out_steady_count == '0 && out_roll_count == '0)
    else $error("settled flag dropped without restart");

endmodule

bind accel_motion_settle_detector amsd_chk u_amsd_chk (.*);

`default_nettype wire

// ----- sim/accel_motion_settle_detector_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_motion_settle_detector_tb - self-checking bench of the settle detector
// Drives samples and restarts through the stall handshake under several gap
// patterns and register settings. A scoreboard predicts each result beat from
// the accepted input beats and compares it, field by field, in order.
// ----------------------------------------------------------------------------

module accel_motion_settle_detector_tb;

  localparam int WIN          = amsd_pkg::WINDOW_DEF;
  localparam int SBITS        = amsd_pkg::SAMPLE_BITS_DEF;
  localparam int SMAX         = (1 << SBITS) - 1;
  localparam int SUM_BITS     = SBITS + $clog2(WIN);
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 6;

  localparam logic CMD_SAMPLE  = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  typedef logic [SBITS-1:0]    sample_t;
  typedef logic [SUM_BITS-1:0] sum_t;
  typedef logic [amsd_pkg::CTR_BITS-1:0]      ctr_t;
  typedef logic [amsd_pkg::CFG_IDX_BITS-1:0]  cfg_idx_t;
  typedef logic [amsd_pkg::CFG_DATA_BITS-1:0] cfg_data_t;

  typedef enum {GAP_NONE, GAP_SENDER, GAP_RECEIVER, GAP_BOTH} gap_mode_t;

  typedef struct packed {
    amsd_pkg::phase_t phase;
    logic             moving;
    sample_t          avg_x;
    sample_t          avg_y;
    sample_t          avg_z;
    ctr_t             steady_count;
    ctr_t             roll_count;
    logic             settled;
  } settle_report_t;

  typedef struct {
    logic    cmd;
    sample_t acc[3];
  } accel_beat_t;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks the detector state and the reports still owed
  // --------------------------------------------------------------------------
  class settle_scoreboard;
    logic [amsd_pkg::WARM_BITS-1:0] warmup;
    logic [amsd_pkg::THR_BITS-1:0]  thresh;
    logic [amsd_pkg::LIM_BITS-1:0]  limit;

    logic [amsd_pkg::CNT_BITS-1:0] sample_cnt;
    logic [$clog2(WIN)-1:0]        ring_pos;
    sample_t                       hist[3][WIN];
    sum_t                          sums[3];
    ctr_t                          steady;
    ctr_t                          rolls;
    bit                            settled;
    logic [WIN-1:0]                written;

    settle_report_t expected_reports[$];
    int faults;

    function new();
      warmup  = amsd_pkg::WARMUP_RST;
      thresh  = amsd_pkg::THR_RST;
      limit   = amsd_pkg::LIM_RST;
      written = '0;
      faults  = 0;
      clear_run();
    endfunction

    function void clear_run();
      sample_cnt = '0;
      ring_pos   = '0;
      sums       = '{default: '0};
      steady     = '0;
      rolls      = '0;
      settled    = 1'b0;
    endfunction

    function void apply_reg(cfg_idx_t idx, cfg_data_t data);
      case (idx)
        amsd_pkg::CFG_WARMUP:       warmup = data[amsd_pkg::WARM_BITS-1:0];
        amsd_pkg::CFG_THRESHOLD:    thresh = data[amsd_pkg::THR_BITS-1:0];
        amsd_pkg::CFG_STEADY_LIMIT: limit  = data[amsd_pkg::LIM_BITS-1:0];
        default: ;
      endcase
    endfunction

    // True once every ring slot holds a sample; rings survive a restart
    function bit ring_primed();
      return &written;
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    // Store one sample, dropping the oldest entry from the sum first if asked
    function void store_sample(sample_t s[3], bit drop);
      int a;
      for (a = 0; a < 3; a++) begin
        if (drop) sums[a] = sums[a] - sum_t'(hist[a][ring_pos]);
        sums[a] = sums[a] + sum_t'(s[a]);
        hist[a][ring_pos] = s[a];
      end
      written[ring_pos] = 1'b1;
      ring_pos = (int'(ring_pos) == WIN - 1) ? '0 : ring_pos + 1'b1;
    endfunction

    // Predict the report for one accepted beat and queue it
    function void note_beat(logic cmd, sample_t x, sample_t y, sample_t z);
      settle_report_t r;
      sample_t s[3];
      int fill_end, a, dev;
      bit moving;
      s      = '{x, y, z};
      r      = '0;
      moving = 1'b0;
      if (cmd == CMD_RESTART) begin
        clear_run();
        expected_reports.push_back(r);
        return;
      end
      if (!settled) begin
        fill_end = int'(warmup) + WIN;
        if (int'(sample_cnt) < int'(warmup)) begin
          r.phase = amsd_pkg::PH_WARMUP;
        end else if (int'(sample_cnt) < fill_end) begin
          r.phase = amsd_pkg::PH_FILL;
          store_sample(s, 1'b0);
        end else begin
          r.phase = amsd_pkg::PH_TRACK;
          store_sample(s, 1'b1);
          for (a = 0; a < 3; a++) begin
            dev = int'(s[a]) - int'(sums[a]) / WIN;
            if (dev < 0) dev = -dev;
            if (dev >= int'(thresh)) moving = 1'b1;
          end
          // the first tracked sample only flags
          if (int'(sample_cnt) > fill_end) begin
            if (moving) begin
              if (rolls != amsd_pkg::CTR_MAX) rolls++;
              steady = '0;
            end else if (steady != amsd_pkg::CTR_MAX) begin
              steady++;
            end
          end
        end
        if (sample_cnt != amsd_pkg::CNT_MAX) sample_cnt++;
      end
      if (steady > limit && rolls != 0) settled = 1'b1;
      if (settled) r.phase = amsd_pkg::PH_DONE;
      r.moving       = moving;
      r.avg_x        = sample_t'(sums[0] / WIN);
      r.avg_y        = sample_t'(sums[1] / WIN);
      r.avg_z        = sample_t'(sums[2] / WIN);
      r.steady_count = steady;
      r.roll_count   = rolls;
      r.settled      = settled;
      expected_reports.push_back(r);
    endfunction

    function string fmt(settle_report_t r);
      return $sformatf("phase=%0d moving=%0d avg=%0d/%0d/%0d steady=%0d rolls=%0d settled=%0d",
                       r.phase, r.moving, r.avg_x, r.avg_y, r.avg_z,
                       r.steady_count, r.roll_count, r.settled);
    endfunction

    function void check_report(settle_report_t got);
      settle_report_t want;
      string bad;
      if (expected_reports.size() == 0) begin
        faults++;
        if (faults <= 10) $display("result beat with nothing pending: %s", fmt(got));
        return;
      end
      want = expected_reports.pop_front();
      bad  = "";
      if (got.phase        !== want.phase)        bad = {bad, " phase"};
      if (got.moving       !== want.moving)       bad = {bad, " moving"};
      if (got.avg_x        !== want.avg_x)        bad = {bad, " avg_x"};
      if (got.avg_y        !== want.avg_y)        bad = {bad, " avg_y"};
      if (got.avg_z        !== want.avg_z)        bad = {bad, " avg_z"};
      if (got.steady_count !== want.steady_count) bad = {bad, " steady_count"};
      if (got.roll_count   !== want.roll_count)   bad = {bad, " roll_count"};
      if (got.settled      !== want.settled)      bad = {bad, " settled"};
      if (bad != "") begin
        faults++;
        if (faults <= 10) begin
          $display("mismatch in%s: expected %s, got %s", bad, fmt(want), fmt(got));
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and the block
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n;

  logic    in_valid, in_stall, in_cmd;
  sample_t in_accel_x, in_accel_y, in_accel_z;

  logic             out_valid;
  logic             out_stall = 1'b0;
  amsd_pkg::phase_t out_phase;
  logic             out_moving;
  sample_t          out_avg_x, out_avg_y, out_avg_z;
  ctr_t             out_steady_count, out_roll_count;
  logic             out_settled;

  logic      cfg_valid, cfg_ready;
  cfg_idx_t  cfg_index;
  cfg_data_t cfg_data;

  settle_scoreboard sb;
  gap_mode_t        gap_mode = GAP_NONE;
  accel_beat_t      accel_beats[$];
  int               quiet_cycles = 0;

  accel_motion_settle_detector u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_accel_x       (in_accel_x),
    .in_accel_y       (in_accel_y),
    .in_accel_z       (in_accel_z),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_phase        (out_phase),
    .out_moving       (out_moving),
    .out_avg_x        (out_avg_x),
    .out_avg_y        (out_avg_y),
    .out_avg_z        (out_avg_z),
    .out_steady_count (out_steady_count),
    .out_roll_count   (out_roll_count),
    .out_settled      (out_settled),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic int gap_pct(gap_mode_t g, bit sender);
    case (g)
      GAP_SENDER:   return sender ? 84 : 0;
      GAP_RECEIVER: return sender ? 0 : 84;
      GAP_BOTH:     return 15;
      default:      return 0;
    endcase
  endfunction

  // Stall the result channel at random
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < gap_pct(gap_mode, 1'b0));
  end

  // Note accepted input beats and check accepted result beats
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      sb.note_beat(in_cmd, in_accel_x, in_accel_y, in_accel_z);
    end
    if (rst_n && out_valid && !out_stall) begin
      sb.check_report('{out_phase, out_moving, out_avg_x, out_avg_y, out_avg_z,
                        out_steady_count, out_roll_count, out_settled});
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("accel_motion_settle_detector test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Drive tasks
  // --------------------------------------------------------------------------
  task automatic write_reg(input cfg_idx_t idx, input int value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value[amsd_pkg::CFG_DATA_BITS-1:0];
    do @(posedge clk); while (!cfg_ready);
    sb.apply_reg(idx, cfg_data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic queue_beat(input logic cmd, input int x, input int y, input int z);
    accel_beat_t b;
    b.cmd    = cmd;
    b.acc[0] = sample_t'(x);
    b.acc[1] = sample_t'(y);
    b.acc[2] = sample_t'(z);
    accel_beats.push_back(b);
  endtask

  // Send every queued beat; hold each one until it is taken
  task automatic drive_beats();
    accel_beat_t b;
    while (accel_beats.size() != 0) begin
      b = accel_beats.pop_front();
      @(negedge clk);
      while ($urandom_range(0, 99) < gap_pct(gap_mode, 1'b1)) begin
        in_valid = 1'b0;
        @(negedge clk);
      end
      in_valid   = 1'b1;
      in_cmd     = b.cmd;
      in_accel_x = b.acc[0];
      in_accel_y = b.acc[1];
      in_accel_z = b.acc[2];
      do @(posedge clk); while (in_stall);
    end
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Wait until every owed report has arrived and the pipeline has drained
  task automatic settle_until_idle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly steady samples around a per-axis level, with jumps and restarts
  task automatic queue_random(input int n, input int rst_pct, input int jump_pct,
                              input int noise);
    int lvl[3];
    int s[3];
    int a, pick;
    for (a = 0; a < 3; a++) lvl[a] = $urandom_range(0, SMAX);
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < rst_pct) begin
        queue_beat(CMD_RESTART, $urandom_range(0, SMAX), $urandom_range(0, SMAX),
                   $urandom_range(0, SMAX));
      end else if (pick < rst_pct + jump_pct) begin
        for (a = 0; a < 3; a++) begin
          s[a] = $urandom_range(0, SMAX);
          if ($urandom_range(0, 2) == 0) lvl[a] = s[a];
        end
        queue_beat(CMD_SAMPLE, s[0], s[1], s[2]);
      end else begin
        for (a = 0; a < 3; a++) begin
          s[a] = lvl[a] + int'($urandom_range(0, 2 * noise)) - noise;
          if (s[a] < 0) s[a] = 0;
          if (s[a] > SMAX) s[a] = SMAX;
        end
        queue_beat(CMD_SAMPLE, s[0], s[1], s[2]);
      end
    end
  endtask

  // One setting of the registers followed by a burst of random beats
  task automatic run_phase(input int warm, input int thr, input int lim, input int n,
                           input gap_mode_t g, input bit fresh, input int rst_pct,
                           input int jump_pct, input int noise);
    settle_until_idle();
    gap_mode = g;
    // restart when asked, or when a new warm-up length could skip an unfilled ring
    if (fresh || (warm != int'(sb.warmup) && !sb.ring_primed())) begin
      queue_beat(CMD_RESTART, $urandom_range(0, SMAX), $urandom_range(0, SMAX),
                 $urandom_range(0, SMAX));
    end
    write_reg(amsd_pkg::CFG_WARMUP, warm);
    write_reg(amsd_pkg::CFG_THRESHOLD, thr);
    write_reg(amsd_pkg::CFG_STEADY_LIMIT, lim);
    queue_random(n, rst_pct, jump_pct, noise);
    drive_beats();
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    sb         = new();
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_cmd     = CMD_SAMPLE;
    in_accel_x = '0;
    in_accel_y = '0;
    in_accel_z = '0;
    cfg_valid  = 1'b0;
    cfg_index  = amsd_pkg::CFG_WARMUP;
    cfg_data   = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // one sample under the reset register values
    queue_beat(CMD_SAMPLE, $urandom_range(0, SMAX), $urandom_range(0, SMAX),
               $urandom_range(0, SMAX));
    drive_beats();

    // directed: short warm-up, extreme fill, one roll then settle
    settle_until_idle();
    write_reg(amsd_pkg::CFG_WARMUP, 1);
    write_reg(amsd_pkg::CFG_THRESHOLD, 300);
    write_reg(amsd_pkg::CFG_STEADY_LIMIT, 0);
    queue_beat(CMD_RESTART, SMAX, SMAX, SMAX);
    queue_beat(CMD_SAMPLE, SMAX, SMAX, SMAX);
    repeat (WIN) queue_beat(CMD_SAMPLE, 0, SMAX, 2048);
    queue_beat(CMD_SAMPLE, 0, SMAX, 2048);
    queue_beat(CMD_SAMPLE, SMAX, 0, 2048);
    queue_beat(CMD_SAMPLE, 0, SMAX, 2048);
    // samples while settled are dropped; restart clears the run
    queue_beat(CMD_SAMPLE, 1234, 77, SMAX);
    queue_beat(CMD_RESTART, 0, 0, 0);
    queue_beat(CMD_SAMPLE, 0, 0, 0);
    drive_beats();

    // random phases: settle, roll saturation with threshold zero,
    // mid-run register changes, longest warm-up
    run_phase(0, 30, 20, 50, GAP_SENDER, 1'b1, 3, 5, 6);
    run_phase(0, 0, 254, 275, GAP_RECEIVER, 1'b1, 0, 0, 20);
    run_phase(3, 1, 0, 40, GAP_BOTH, 1'b1, 3, 10, 1);
    run_phase(1023, SMAX, 0, 15, GAP_NONE, 1'b0, 3, 10, 8);
    run_phase(2, 12, 3, 40, GAP_SENDER, 1'b0, 3, 6, 4);

    settle_until_idle();
    if (sb.faults == 0 && sb.pending() == 0) begin
      $display("accel_motion_settle_detector test passed");
    end else begin
      $display("accel_motion_settle_detector test failed");
    end
    $finish;
  end

endmodule

// ----- accel_motion_settle_detector.f -----
design/amsd_pkg.sv
design/amsd_split.sv
design/amsd_lane.sv
design/amsd_merge.sv
design/accel_motion_settle_detector.sv
design/amsd_chk.sv
sim/accel_motion_settle_detector_tb.sv
